### design/bdpc_pkg.sv
// shared types and constants for the button debounce and press classifier
// no dependencies; imported by every module of the block
package bdpc_pkg;

  localparam int SAMPLES     = 10;
  localparam int BUTTONS     = 3;
  localparam int HALF_WINDOW = SAMPLES / 2;
  localparam int CNT_W       = $clog2(SAMPLES + 1);
  localparam int POS_W       = $clog2(SAMPLES);
  localparam int HOLD_W      = 16;
  localparam int RAW_W       = 3;
  localparam int MASK_W      = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
  localparam logic [CFG_W-1:0]  PRESS_TIME_RST      = CFG_W'(50);
  localparam logic [CFG_W-1:0]  LONG_PRESS_TIME_RST = CFG_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIME      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CFG_W-1:0] press_time;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic short_rel;
    logic long_rel;
  } lane_res_t;

  typedef struct packed {
    logic              window_done;
    logic [MASK_W-1:0] long_release_mask;
    logic [MASK_W-1:0] short_release_mask;
    logic [MASK_W-1:0] pressed_mask;
  } result_t;

endpackage

### design/bdpc_lane.sv
// one button lane: window high count, debounced state, hold counter, release class
// depends on bdpc_pkg
module bdpc_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              raw_bit,
  input  logic              window_end,
  input  bdpc_pkg::cfg_t    cfg,
  output bdpc_pkg::lane_res_t res
);
  import bdpc_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [HOLD_W-1:0] hold_r, hold_nxt, hold_inc;
  logic              pressed_r, pressed_nxt;
  logic              level;

  always_comb begin
    hold_inc = (pressed_r && hold_r != HOLD_MAX) ? hold_r + HOLD_W'(1) : hold_r;
    cnt_inc  = raw_bit ? cnt_r + CNT_W'(1) : cnt_r;
    level    = cnt_inc > CNT_W'(HALF_WINDOW);
    cnt_nxt     = cnt_inc;
    hold_nxt    = hold_inc;
    pressed_nxt = pressed_r;
    res.short_rel = 1'b0;
    res.long_rel  = 1'b0;
    if (window_end) begin
      cnt_nxt = '0;
      if (level && !pressed_r) begin
        pressed_nxt = 1'b1;
        hold_nxt    = '0;
      end else if (!level && pressed_r) begin
        pressed_nxt = 1'b0;
        hold_nxt    = '0;
        // long wins over short when thresholds are inverted
        res.long_rel  = hold_inc >= cfg.long_press_time;
        res.short_rel = !res.long_rel && (hold_inc >= cfg.press_time);
      end
    end
    res.pressed = pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      hold_r    <= '0;
      pressed_r <= 1'b0;
    end else if (step) begin
      cnt_r     <= cnt_nxt;
      hold_r    <= hold_nxt;
      pressed_r <= pressed_nxt;
    end
  end

endmodule

### design/bdpc_merge.sv
// merges lane results into masks and holds them in a two-entry output stage
// depends on bdpc_pkg
module bdpc_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  bdpc_pkg::lane_res_t [bdpc_pkg::BUTTONS-1:0] lanes,
  input  logic                            window_end,
  output logic                            ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdpc_pkg::result_t               out_res
);
  import bdpc_pkg::*;

  result_t merged;
  result_t main_r, skid_r;
  logic    main_valid_r, skid_valid_r;
  logic    out_fire;

  // buttons beyond the mask width are dropped, missing ones read as zero
  for (genvar i = 0; i < MASK_W; i++) begin : g_bit
    if (i < BUTTONS) begin : g_lane
      assign merged.pressed_mask[i]       = lanes[i].pressed;
      assign merged.short_release_mask[i] = lanes[i].short_rel;
      assign merged.long_release_mask[i]  = lanes[i].long_rel;
    end else begin : g_none
      assign merged.pressed_mask[i]       = 1'b0;
      assign merged.short_release_mask[i] = 1'b0;
      assign merged.long_release_mask[i]  = 1'b0;
    end
  end
  assign merged.window_done = window_end;

  assign out_fire  = main_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (step) begin
      if (main_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        main_r <= skid_r;
      end
    end else if (step) begin
      if (main_valid_r && !out_ready) begin
        skid_r <= merged;
      end else begin
        main_r <= merged;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without a main entry");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !step)
    else $error("item accepted while output stage full");

  a_short_long_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r |-> (main_r.short_release_mask & main_r.long_release_mask) == '0)
    else $error("button classed both short and long");

  a_release_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r |->
      ((main_r.short_release_mask | main_r.long_release_mask) & main_r.pressed_mask) == '0)
    else $error("released button still shown pressed");

  a_release_on_window: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !main_r.window_done) |->
      (main_r.short_release_mask | main_r.long_release_mask) == '0)
    else $error("release event outside a window close");
`endif

endmodule

### design/button_debounce_press_classifier.sv
// top level of the button debounce and press classifier
// depends on bdpc_pkg, bdpc_lane and bdpc_merge
//
// channel   direction  tdata bits (low first)                          accept
// in_       in         raw_levels[2:0], pad                            tvalid & tready
// out_      out        pressed[2:0] short[5:3] long[8:6] done[9], pad  tvalid & tready
// cfg_      in         index 0 press_time, 1 long_press_time           cfg_we
//
// one item per clock while out_tready is high; each item gives one registered result
// the per-button lanes update all state in the accept cycle, so the window
// counter and hold counters never limit the rate
// reset is synchronous and active low: counts, hold times and pressed state
// clear, press_time returns to 50 and long_press_time to 1000
// a two-entry output stage keeps in_tready high until its skid entry fills
module button_debounce_press_classifier (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [bdpc_pkg::IN_TDATA_W-1:0]        in_tdata,   // raw_levels, zero pad
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [bdpc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // pressed_mask,
                                                             // short_release_mask,
                                                             // long_release_mask,
                                                             // window_done, zero pad
  input  logic                                   cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bdpc_pkg::CFG_W-1:0]             cfg_wdata
);
  import bdpc_pkg::*;

  cfg_t                      cfg_r;
  logic [POS_W-1:0]          pos_r;
  logic                      step;
  logic                      window_end;
  logic [RAW_W-1:0]          raw;
  lane_res_t [BUTTONS-1:0]   lanes;
  result_t                   res;

  // configuration writes, ignored index codes fall to default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_time      <= PRESS_TIME_RST;
      cfg_r.long_press_time <= LONG_PRESS_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_TIME:      cfg_r.press_time      <= cfg_wdata;
        REG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign step       = in_tvalid && in_tready;
  assign raw        = in_tdata[RAW_W-1:0];
  // the accepted item closes the window when it is the last sample
  assign window_end = pos_r == POS_W'(SAMPLES - 1);

  // shared window position for all lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= window_end ? '0 : pos_r + POS_W'(1);
    end
  end

  // one lane per button; buttons without an input bit see a low level
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    logic raw_bit;
    if (b < RAW_W) begin : g_in
      assign raw_bit = raw[b];
    end else begin : g_low
      assign raw_bit = 1'b0;
    end
    bdpc_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .raw_bit    (raw_bit),
      .window_end (window_end),
      .cfg        (cfg_r),
      .res        (lanes[b])
    );
  end

  bdpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .lanes      (lanes),
    .window_end (window_end),
    .ready      (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = OUT_TDATA_W'(res);

endmodule

### test/button_debounce_press_classifier_tb.sv
// testbench for button_debounce_press_classifier: windowed debounce, hold timing
// and short/long release classification; depends on bdpc_pkg and the design top
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  // tracks the block: window counts, pressed state, hold counters, thresholds
  // and keeps the predicted result of every accepted item in arrival order
  class press_scoreboard;
    logic [CFG_W-1:0]  min_short_ticks;
    logic [CFG_W-1:0]  min_long_ticks;
    logic [3:0]        high_count [BUTTONS];
    logic [3:0]        window_pos;
    logic              held [BUTTONS];
    logic [HOLD_W-1:0] hold_count [BUTTONS];
    result_t           expected_q [$];
    int unsigned       fail_count;

    function new();
      min_short_ticks = PRESS_TIME_RST;
      min_long_ticks  = LONG_PRESS_TIME_RST;
      window_pos      = '0;
      fail_count      = 0;
      for (int b = 0; b < BUTTONS; b++) begin
        high_count[b] = '0;
        held[b]       = 1'b0;
        hold_count[b] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_PRESS_TIME) min_short_ticks = val;
      else if (idx == REG_LONG_PRESS_TIME) min_long_ticks = val;
    endfunction

    // one sample tick: advance the hold counters, count highs, decide at window end
    function void note_levels(logic [RAW_W-1:0] raw);
      result_t r;
      logic    closes;
      logic    level;
      r = '0;
      for (int b = 0; b < BUTTONS; b++) begin
        if (held[b] && hold_count[b] != HOLD_MAX) hold_count[b] += 1'b1;
        if (raw[b]) high_count[b] += 1'b1;
      end
      closes = (int'(window_pos) + 1) >= SAMPLES;
      if (closes) begin
        for (int b = 0; b < BUTTONS; b++) begin
          level = high_count[b] > HALF_WINDOW;
          if (level && !held[b]) begin
            held[b]       = 1'b1;
            hold_count[b] = '0;
          end else if (!level && held[b]) begin
            held[b] = 1'b0;
            if (hold_count[b] >= min_short_ticks && hold_count[b] < min_long_ticks)
              r.short_release_mask[b] = 1'b1;
            else if (hold_count[b] >= min_long_ticks)
              r.long_release_mask[b] = 1'b1;
            hold_count[b] = '0;
          end
          high_count[b] = '0;
        end
        window_pos = '0;
      end else begin
        window_pos += 1'b1;
      end
      for (int b = 0; b < BUTTONS; b++) r.pressed_mask[b] = held[b];
      r.window_done = closes;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      result_t want;
      result_t got;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: tdata %h", tdata);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      got  = tdata[$bits(result_t)-1:0];
      compare_field("pressed_mask", 8'(want.pressed_mask), 8'(got.pressed_mask));
      compare_field("short_release_mask", 8'(want.short_release_mask),
                    8'(got.short_release_mask));
      compare_field("long_release_mask", 8'(want.long_release_mask),
                    8'(got.long_release_mask));
      compare_field("window_done", 8'(want.window_done), 8'(got.window_done));
      compare_field("pad", 8'h00, 8'(tdata[OUT_TDATA_W-1:$bits(result_t)]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // raw_levels[2:0], zero pad
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // pressed_mask, short_release_mask,
                                       // long_release_mask, window_done, zero pad
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  press_scoreboard sb;

  // stimulus state: wanted level per button and windows left in its current run
  logic level_want [BUTTONS];
  int   run_left [BUTTONS];
  // when set, neither side idles (stretches of full rate)
  bit   calm;

  button_debounce_press_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: stalls of random length between ready runs
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  // every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // register writes happen only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // one sample tick: optional idle gap, then hold valid until accepted
  task automatic drive_levels(input logic [RAW_W-1:0] raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(raw);
    do @(posedge clk); while (!in_tready);
    sb.note_levels(raw);
  endtask

  // stop sending and wait for every pending result, plus a little slack
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one full window of ticks; each button follows runs of pressed / released
  // windows with some noisy windows mixed in; force_enter >= 0 pins the
  // high percentage of the enter button
  task automatic drive_window(input int force_enter);
    int               pct [BUTTONS];
    logic [RAW_W-1:0] raw;
    for (int b = 0; b < BUTTONS; b++) begin
      if (run_left[b] == 0) begin
        level_want[b] = !level_want[b];
        run_left[b] = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                                 : $urandom_range(7, 12);
      end
      run_left[b]--;
      if ($urandom_range(0, 9) == 0) pct[b] = $urandom_range(0, 100);
      else pct[b] = level_want[b] ? $urandom_range(75, 100) : $urandom_range(0, 25);
    end
    if (force_enter >= 0) pct[0] = force_enter;
    for (int j = 0; j < SAMPLES; j++) begin
      for (int b = 0; b < BUTTONS; b++) raw[b] = $urandom_range(0, 99) < pct[b];
      drive_levels(raw);
    end
  endtask

  // random windows; now and then the sender holds off until all results are in
  task automatic run_windows(input int windows);
    calm = ($urandom_range(0, 3) == 0);
    repeat (windows) begin
      drive_window(-1);
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic random_thresholds();
    logic [CFG_W-1:0] short_min;
    logic [CFG_W-1:0] long_min;
    short_min = CFG_W'($urandom_range(0, 80));
    if ($urandom_range(0, 4) == 0) long_min = CFG_W'($urandom_range(0, short_min));
    else long_min = CFG_W'(short_min + $urandom_range(0, 60));
    write_reg(REG_PRESS_TIME, short_min);
    write_reg(REG_LONG_PRESS_TIME, long_min);
  endtask

  // watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [RAW_W-1:0] directed [2*SAMPLES];
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    calm       = 1'b0;
    for (int b = 0; b < BUTTONS; b++) begin
      level_want[b] = 1'b0;
      run_left[b]   = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed window 1: enter exactly one high over half (press), up exactly
    // half (stays released), down high all window; window 2 all low releases
    // enter and down after a hold far too short for the reset thresholds
    for (int j = 0; j < SAMPLES; j++) begin
      directed[j][0] = (j < 6);
      directed[j][1] = (j >= 5);
      directed[j][2] = 1'b1;
      directed[SAMPLES + j] = '0;
    end
    foreach (directed[j]) drive_levels(directed[j]);
    drain_results();

    // reset thresholds: short presses only
    run_windows(25);

    // both thresholds zero: every release is a long press
    write_reg(REG_PRESS_TIME, '0);
    write_reg(REG_LONG_PRESS_TIME, '0);
    run_windows(20);

    // inverted thresholds: no short press possible
    write_reg(REG_PRESS_TIME, CFG_W'(40));
    write_reg(REG_LONG_PRESS_TIME, CFG_W'(20));
    run_windows(20);

    // largest press_time against a small long_press_time
    write_reg(REG_PRESS_TIME, {CFG_W{1'b1}});
    write_reg(REG_LONG_PRESS_TIME, CFG_W'(30));
    run_windows(10);

    // zero press_time with the largest long_press_time: every release is short
    write_reg(REG_PRESS_TIME, '0);
    write_reg(REG_LONG_PRESS_TIME, {CFG_W{1'b1}});
    run_windows(7);

    // assorted small thresholds
    repeat (3) begin
      random_thresholds();
      run_windows(17);
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/bdpc_pkg.sv
design/bdpc_lane.sv
design/bdpc_merge.sv
design/button_debounce_press_classifier.sv
test/button_debounce_press_classifier_tb.sv
